/* rtl/hdr_pkg.sv */
// ----------------------------------------------------------------------------
// Heat diffusion row step package
// Shared sizes, arithmetic widths and the sequencer state type of the block.
// ----------------------------------------------------------------------------
package hdr_pkg;

	localparam int CELLS   = 64;
	localparam int IDX_W   = 6;
	localparam int DATA_W  = 32;
	localparam int RATIO_W = 32;
	localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNT_W   = $clog2(CELLS + 1);
	localparam int LAP_W   = DATA_W + 3;
	localparam int HALF_W  = RATIO_W / 2 + 1;
	localparam int PROD_W  = LAP_W + HALF_W;
	localparam int ACC_W   = PROD_W + RATIO_W / 2;
	localparam int DELTA_W = ACC_W - RATIO_W;
	localparam int SUM_W   = DELTA_W + 1;

	localparam logic [RATIO_W-1:0] RATIO_RST = 32'd42950;
	localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(64'sd2147483648);

	typedef logic signed [DATA_W-1:0] temp_t;

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} hdr_state_t;

endpackage

/* rtl/hdr_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module hdr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/heat_diffusion_row_step.sv */
// ----------------------------------------------------------------------------
// Heat diffusion row step
// One explicit time step of the 1-D heat equation per input transfer.
// ----------------------------------------------------------------------------
// The rod of CELLS signed Q16.16 temperatures lives in a RAM with one read
// and one write port; per-cell valid flags make it read as zero after reset.
// An input transfer may overwrite one cell, then a sweep reads the rod once
// (CELLS + 1 read slots, the last one standing for the zero beyond the right
// edge) and a five-stage datapath emits one result per cycle unless the
// output stalls, writing each new cell back. A new transfer is taken only
// after the sweep has ended and the stages ahead of the output register are
// empty. The diffusion ratio may only be written while no step is in
// progress.
module heat_diffusion_row_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hdr_pkg::RATIO_W-1:0]  diffusion_ratio,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         inject_enable,
	input  logic [hdr_pkg::IDX_W-1:0]    inject_cell,
	input  logic signed [hdr_pkg::DATA_W-1:0] inject_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hdr_pkg::IDX_W-1:0]    cell_index,
	output logic signed [hdr_pkg::DATA_W-1:0] temperature,
	output logic                         last_cell
);

	hdr_pkg::hdr_state_t state_q, state_d;

	logic [hdr_pkg::CNT_W-1:0]   rd_q;
	logic [hdr_pkg::RATIO_W-1:0] ratio_q;
	logic                        inj_en_q;
	logic [hdr_pkg::IDX_W-1:0]   inj_cell_q;
	hdr_pkg::temp_t              inj_val_q;
	logic [hdr_pkg::CELLS-1:0]   cell_vld_q;
	hdr_pkg::temp_t              left_q, cen_q;

	logic                        val_s1, vld_s1;
	logic [hdr_pkg::CNT_W-1:0]   idx_s1;
	logic                        v_s2, v_s3, v_s4;
	logic signed [hdr_pkg::LAP_W-1:0]  lap_s2;
	hdr_pkg::temp_t              t_s2, t_s3, t_s4;
	logic [hdr_pkg::ADDR_W-1:0]  idx_s2, idx_s3, idx_s4;
	logic signed [hdr_pkg::PROD_W-1:0] hi_s3, lo_s3;
	logic signed [hdr_pkg::DELTA_W-1:0] delta_s4;

	logic                        out_valid_q, out_last_q;
	logic [hdr_pkg::ADDR_W-1:0]  out_idx_q;
	hdr_pkg::temp_t              out_temp_q;

	logic                        adv, busy, accept, issue, end_rd;
	logic [hdr_pkg::DATA_W-1:0]  ram_rdata;
	hdr_pkg::temp_t              right_c, sat_c;
	logic signed [hdr_pkg::LAP_W-1:0]  lap_c;
	logic signed [hdr_pkg::HALF_W-1:0] rh_c, rl_c;
	logic signed [hdr_pkg::PROD_W-1:0] hi_c, lo_c;
	logic signed [hdr_pkg::ACC_W-1:0]  acc_c;
	logic signed [hdr_pkg::SUM_W-1:0]  sum_c;
	logic [hdr_pkg::SUM_W-hdr_pkg::DATA_W:0] top_c;

	assign adv      = !out_valid_q || !out_stall;
	assign busy     = (state_q == hdr_pkg::ST_SWEEP) || val_s1 || v_s2 || v_s3 || v_s4;
	assign in_stall = busy;
	assign accept   = in_valid && !busy;
	assign end_rd   = (rd_q == hdr_pkg::CNT_W'(hdr_pkg::CELLS));
	assign issue    = (state_q == hdr_pkg::ST_SWEEP) && adv;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hdr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = hdr_pkg::ST_SWEEP;
				end
			end
			hdr_pkg::ST_SWEEP: begin
				if (issue && end_rd) begin
					state_d = hdr_pkg::ST_IDLE;
				end
			end
			default: state_d = hdr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hdr_pkg::ST_IDLE;
			rd_q        <= '0;
			ratio_q     <= hdr_pkg::RATIO_RST;
			cell_vld_q  <= '0;
			val_s1      <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				ratio_q <= diffusion_ratio;
			end
			if (accept) begin
				rd_q <= '0;
			end else if (issue) begin
				rd_q <= rd_q + 1'b1;
			end
			if (adv) begin
				val_s1      <= issue;
				v_s2        <= val_s1 && (idx_s1 != '0);
				v_s3        <= v_s2;
				v_s4        <= v_s3;
				out_valid_q <= v_s4;
				if (v_s4) begin
					cell_vld_q[idx_s4] <= 1'b1;
				end
			end
		end
	end

	hdr_ram #(
		.WIDTH(hdr_pkg::DATA_W),
		.DEPTH(hdr_pkg::CELLS)
	) u_rod (
		.clk  (clk),
		.we   (adv && v_s4),
		.waddr(idx_s4),
		.wdata(sat_c),
		.re   (issue && !end_rd),
		.raddr(rd_q[hdr_pkg::ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (idx_s1 == hdr_pkg::CNT_W'(hdr_pkg::CELLS)) begin
			right_c = '0;
		end else if (inj_en_q && ((hdr_pkg::IDX_W + 1)'(idx_s1) ==
				(hdr_pkg::IDX_W + 1)'(inj_cell_q))) begin
			right_c = inj_val_q;
		end else if (vld_s1) begin
			right_c = ram_rdata;
		end else begin
			right_c = '0;
		end
	end

	assign lap_c = hdr_pkg::LAP_W'(left_q) - (hdr_pkg::LAP_W'(cen_q) <<< 1)
		+ hdr_pkg::LAP_W'(right_c);
	assign rh_c  = $signed({1'b0, ratio_q[hdr_pkg::RATIO_W-1:hdr_pkg::RATIO_W/2]});
	assign rl_c  = $signed({1'b0, ratio_q[hdr_pkg::RATIO_W/2-1:0]});
	assign hi_c  = lap_s2 * rh_c;
	assign lo_c  = lap_s2 * rl_c;
	assign acc_c = (hdr_pkg::ACC_W'(hi_s3) <<< (hdr_pkg::RATIO_W / 2))
		+ hdr_pkg::ACC_W'(lo_s3) + hdr_pkg::ROUND_C;
	assign sum_c = hdr_pkg::SUM_W'(t_s4) + hdr_pkg::SUM_W'(delta_s4);
	assign top_c = sum_c[hdr_pkg::SUM_W-1:hdr_pkg::DATA_W-1];

	always_comb begin
		if ((&top_c) || !(|top_c)) begin
			sat_c = sum_c[hdr_pkg::DATA_W-1:0];
		end else if (sum_c[hdr_pkg::SUM_W-1]) begin
			sat_c = {1'b1, {(hdr_pkg::DATA_W - 1){1'b0}}};
		end else begin
			sat_c = {1'b0, {(hdr_pkg::DATA_W - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inj_en_q   <= inject_enable;
			inj_cell_q <= inject_cell;
			inj_val_q  <= inject_value;
			left_q     <= '0;
			cen_q      <= '0;
		end else if (adv && val_s1) begin
			left_q <= cen_q;
			cen_q  <= right_c;
		end
		if (adv) begin
			idx_s1   <= rd_q;
			vld_s1   <= end_rd ? 1'b0 : cell_vld_q[rd_q[hdr_pkg::ADDR_W-1:0]];
			lap_s2   <= lap_c;
			t_s2     <= cen_q;
			idx_s2   <= hdr_pkg::ADDR_W'(idx_s1 - 1'b1);
			hi_s3    <= hi_c;
			lo_s3    <= lo_c;
			t_s3     <= t_s2;
			idx_s3   <= idx_s2;
			delta_s4 <= acc_c[hdr_pkg::ACC_W-1:hdr_pkg::RATIO_W];
			t_s4     <= t_s3;
			idx_s4   <= idx_s3;
			out_temp_q <= sat_c;
			out_idx_q  <= idx_s4;
			out_last_q <= (idx_s4 == hdr_pkg::ADDR_W'(hdr_pkg::CELLS - 1));
		end
	end

	assign out_valid   = out_valid_q;
	assign temperature = out_temp_q;
	assign cell_index  = hdr_pkg::IDX_W'(out_idx_q);
	assign last_cell   = out_last_q;

endmodule

/* rtl/hdr_checker.sv */
// ----------------------------------------------------------------------------
// Heat diffusion row step checker
// Port-level properties of the row step, bound to the top level.
// ----------------------------------------------------------------------------
module hdr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [hdr_pkg::IDX_W-1:0]          cell_index,
	input logic signed [hdr_pkg::DATA_W-1:0]  temperature,
	input logic                               last_cell
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(temperature)
			&& $stable(cell_index) && $stable(last_cell))
		else $error("stalled result changed");

	// The final cell of a row is the last cell of the rod.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_cell == (cell_index ==
			hdr_pkg::IDX_W'(hdr_pkg::CELLS - 1))))
		else $error("last cell flag and cell index disagree");

	// An accepted transfer starts a step, so the input stalls next.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	// No new item is taken while a row is only partly delivered.
	a_no_accept_mid_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_cell |-> in_stall)
		else $error("input accepted in the middle of a row");

endmodule

bind heat_diffusion_row_step hdr_checker u_hdr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.cell_index (cell_index),
	.temperature(temperature),
	.last_cell  (last_cell)
);
